### rtl/core/assert_macros.svh
// assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on i_clk outside reset
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("core assertion failed");

// next-cycle implication, checked on i_clk outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("core assertion failed");

`endif

### rtl/core/gnps_pkg.sv
// types, codes and microcode program of the grouped permutation core
`timescale 1ns / 1ps
package gnps_pkg;

    localparam int POS_W      = 3;
    localparam int VAL_W      = 8;
    localparam int DIM_W      = 4;
    localparam int CODES_W    = 16;
    localparam int CODE_SLOTS = CODES_W / 2;
    localparam int CFG_W      = 16;

    typedef enum logic {
        CFG_DIM_COUNT = 1'b0,
        CFG_SYM_CODES = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_ADVANCE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        SYM_NONE  = 2'd0,
        SYM_SYM   = 2'd1,
        SYM_ANTI  = 2'd2,
        SYM_HERM  = 2'd3
    } t_sym;

    localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

    typedef logic [4:0] t_pc;

    // program addresses
    localparam t_pc S_IDLE      = 5'd0;
    localparam t_pc S_CHK       = 5'd1;
    localparam t_pc S_SCAN      = 5'd2;
    localparam t_pc S_SCAN_INC  = 5'd3;
    localparam t_pc S_PIV_INIT  = 5'd4;
    localparam t_pc S_PIV_RD    = 5'd5;
    localparam t_pc S_PIV_CMP   = 5'd6;
    localparam t_pc S_PIV_DEC   = 5'd7;
    localparam t_pc S_PIV_LOOP  = 5'd8;
    localparam t_pc S_FOUND     = 5'd9;
    localparam t_pc S_SUCC_RD   = 5'd10;
    localparam t_pc S_SUCC_CMP  = 5'd11;
    localparam t_pc S_SUCC_DEC  = 5'd12;
    localparam t_pc S_SWAP_L    = 5'd13;
    localparam t_pc S_SWAP_M    = 5'd14;
    localparam t_pc S_TAIL      = 5'd15;
    localparam t_pc S_WRAP      = 5'd16;
    localparam t_pc S_REV       = 5'd17;
    localparam t_pc S_REV_RD    = 5'd18;
    localparam t_pc S_REV_WA    = 5'd19;
    localparam t_pc S_REV_WB    = 5'd20;
    localparam t_pc S_REV_END   = 5'd21;
    localparam t_pc S_NEXT_GRP  = 5'd22;
    localparam t_pc S_EMIT      = 5'd23;
    localparam t_pc S_EMIT_RD   = 5'd24;
    localparam t_pc S_EMIT_WAIT = 5'd25;
    localparam t_pc S_EMIT_OUT  = 5'd26;
    localparam t_pc S_EMIT_LOOP = 5'd27;
    localparam t_pc S_EMPTY     = 5'd28;
    localparam t_pc S_EMPTY_OUT = 5'd29;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_IDLE,
        OP_INC_I,
        OP_SET_L,
        OP_RD_L,
        OP_DEC_L,
        OP_SET_M,
        OP_RD_M,
        OP_DEC_M,
        OP_WR_L,
        OP_WR_M,
        OP_SET_TAIL,
        OP_SET_WRAP,
        OP_RD_AB,
        OP_WR_A,
        OP_WR_B,
        OP_PARITY,
        OP_NEXT_GRP,
        OP_SET_K,
        OP_RD_K,
        OP_EMIT,
        OP_EMIT_EMPTY
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ADV,
        C_N_ZERO,
        C_GROUP_END,
        C_I_EQ_START,
        C_LESS,
        C_L_EQ_START,
        C_A_GE_B,
        C_NOT_WRAP,
        C_NOT_I_LAST,
        C_OUT_BUSY,
        C_K_LAST
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_pc  pc;
        t_op  op;
        logic idle;
    } t_ctrl;

    // datapath flags tested by jumps
    typedef struct packed {
        logic adv_accept;
        logic n_zero;
        logic group_end;
        logic i_eq_start;
        logic less;
        logic l_eq_start;
        logic a_ge_b;
        logic wrapping;
        logic i_last;
        logic out_busy;
        logic k_last;
    } t_stat;

    function automatic t_uword uw(input t_op op, input t_cond cond, input t_pc target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // control store: jump to target when cond holds, else fall through
    function automatic t_uword uc_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            S_IDLE:      w = uw(OP_IDLE,       C_NO_ADV,     S_IDLE);
            S_CHK:       w = uw(OP_NOP,        C_N_ZERO,     S_EMPTY);
            S_SCAN:      w = uw(OP_NOP,        C_GROUP_END,  S_PIV_INIT);
            S_SCAN_INC:  w = uw(OP_INC_I,      C_ALWAYS,     S_SCAN);
            S_PIV_INIT:  w = uw(OP_SET_L,      C_I_EQ_START, S_WRAP);
            S_PIV_RD:    w = uw(OP_RD_L,       C_NEVER,      S_IDLE);
            S_PIV_CMP:   w = uw(OP_NOP,        C_LESS,       S_FOUND);
            S_PIV_DEC:   w = uw(OP_DEC_L,      C_L_EQ_START, S_WRAP);
            S_PIV_LOOP:  w = uw(OP_NOP,        C_ALWAYS,     S_PIV_RD);
            S_FOUND:     w = uw(OP_SET_M,      C_NEVER,      S_IDLE);
            S_SUCC_RD:   w = uw(OP_RD_M,       C_NEVER,      S_IDLE);
            S_SUCC_CMP:  w = uw(OP_NOP,        C_LESS,       S_SWAP_L);
            S_SUCC_DEC:  w = uw(OP_DEC_M,      C_ALWAYS,     S_SUCC_RD);
            S_SWAP_L:    w = uw(OP_WR_L,       C_NEVER,      S_IDLE);
            S_SWAP_M:    w = uw(OP_WR_M,       C_NEVER,      S_IDLE);
            S_TAIL:      w = uw(OP_SET_TAIL,   C_ALWAYS,     S_REV);
            S_WRAP:      w = uw(OP_SET_WRAP,   C_NEVER,      S_IDLE);
            S_REV:       w = uw(OP_NOP,        C_A_GE_B,     S_REV_END);
            S_REV_RD:    w = uw(OP_RD_AB,      C_NEVER,      S_IDLE);
            S_REV_WA:    w = uw(OP_WR_A,       C_NEVER,      S_IDLE);
            S_REV_WB:    w = uw(OP_WR_B,       C_ALWAYS,     S_REV);
            S_REV_END:   w = uw(OP_PARITY,     C_NOT_WRAP,   S_EMIT);
            S_NEXT_GRP:  w = uw(OP_NEXT_GRP,   C_NOT_I_LAST, S_SCAN);
            S_EMIT:      w = uw(OP_SET_K,      C_NEVER,      S_IDLE);
            S_EMIT_RD:   w = uw(OP_RD_K,       C_NEVER,      S_IDLE);
            S_EMIT_WAIT: w = uw(OP_NOP,        C_OUT_BUSY,   S_EMIT_WAIT);
            S_EMIT_OUT:  w = uw(OP_EMIT,       C_K_LAST,     S_IDLE);
            S_EMIT_LOOP: w = uw(OP_NOP,        C_ALWAYS,     S_EMIT_RD);
            S_EMPTY:     w = uw(OP_NOP,        C_OUT_BUSY,   S_EMPTY);
            S_EMPTY_OUT: w = uw(OP_EMIT_EMPTY, C_ALWAYS,     S_IDLE);
            default:     w = uw(OP_NOP,        C_ALWAYS,     S_IDLE);
        endcase
        return w;
    endfunction

endpackage

### rtl/core/gnps_in_if.sv
// input item channel of the grouped permutation core
`timescale 1ns / 1ps
interface gnps_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [gnps_pkg::POS_W-1:0] position;
    logic [gnps_pkg::VAL_W-1:0] index_value;

    modport source (output valid, kind, position, index_value, input ready);
    modport sink   (input valid, kind, position, index_value, output ready);
endinterface

### rtl/core/gnps_out_if.sv
// result item channel of the grouped permutation core
`timescale 1ns / 1ps
interface gnps_out_if;
    logic                        valid;
    logic                        ready;
    logic [gnps_pkg::POS_W-1:0] out_position;
    logic [gnps_pkg::VAL_W-1:0] out_value;
    logic signed [1:0]           sign;
    logic                        last;

    modport source (output valid, out_position, out_value, sign, last, input ready);
    modport sink   (input valid, out_position, out_value, sign, last, output ready);
endinterface

### rtl/core/gnps_ram.sv
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
module gnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re_a,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic             i_re_b,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

### rtl/core/gnps_seq.sv
// microcode sequencer: step counter, control store and conditional jumps
`timescale 1ns / 1ps
module gnps_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gnps_pkg::t_stat i_stat,
    output gnps_pkg::t_ctrl o_ctrl
);
    gnps_pkg::t_pc    r_pc;
    gnps_pkg::t_pc    n_pc;
    gnps_pkg::t_uword uword;
    logic             take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= gnps_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        uword = gnps_pkg::uc_rom(r_pc);
        unique case (uword.cond)
            gnps_pkg::C_NEVER:      take = 1'b0;
            gnps_pkg::C_ALWAYS:     take = 1'b1;
            gnps_pkg::C_NO_ADV:     take = !i_stat.adv_accept;
            gnps_pkg::C_N_ZERO:     take = i_stat.n_zero;
            gnps_pkg::C_GROUP_END:  take = i_stat.group_end;
            gnps_pkg::C_I_EQ_START: take = i_stat.i_eq_start;
            gnps_pkg::C_LESS:       take = i_stat.less;
            gnps_pkg::C_L_EQ_START: take = i_stat.l_eq_start;
            gnps_pkg::C_A_GE_B:     take = i_stat.a_ge_b;
            gnps_pkg::C_NOT_WRAP:   take = !i_stat.wrapping;
            gnps_pkg::C_NOT_I_LAST: take = !i_stat.i_last;
            gnps_pkg::C_OUT_BUSY:   take = i_stat.out_busy;
            gnps_pkg::C_K_LAST:     take = i_stat.k_last;
            default:                take = 1'b1;
        endcase
        n_pc        = take ? uword.target : r_pc + 5'd1;
        o_ctrl.pc   = r_pc;
        o_ctrl.op   = uword.op;
        o_ctrl.idle = (r_pc == gnps_pkg::S_IDLE);
    end
endmodule

### rtl/core/gnps_dp.sv
// datapath: configuration, index store, pointers, sign and result register
`timescale 1ns / 1ps
module gnps_dp #(
    parameter int MAX_DIMS    = 8,
    parameter int INDEX_WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [gnps_pkg::CFG_W-1:0] i_cfg_wdata,
    input  gnps_pkg::t_ctrl   i_ctrl,
    output gnps_pkg::t_stat   o_stat,
    gnps_in_if.sink           i_in,
    gnps_out_if.source        o_out
);
    localparam int IW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CW    = $clog2(MAX_DIMS + 1);
    localparam int POS_W = gnps_pkg::POS_W;
    localparam int VAL_W = gnps_pkg::VAL_W;

    logic [gnps_pkg::DIM_W-1:0]   r_dim_count;
    logic [gnps_pkg::CODES_W-1:0] r_sym_codes;
    logic [MAX_DIMS-1:0] r_vld, n_vld;
    logic r_rvld_a, n_rvld_a, r_rvld_b, n_rvld_b;
    logic [CW-1:0] r_n, n_n;
    logic [IW-1:0] r_start, n_start, r_i, n_i, r_l, n_l, r_m, n_m;
    logic [IW-1:0] r_a, n_a, r_b, n_b, r_k, n_k;
    logic r_neg, n_neg, r_fin, n_fin, r_par, n_par, r_wrap, n_wrap;
    logic r_out_valid, n_out_valid;
    logic [POS_W-1:0] r_out_pos, n_out_pos;
    logic [VAL_W-1:0] r_out_val, n_out_val;
    logic signed [1:0] r_out_sign, n_out_sign;
    logic r_out_last, n_out_last;

    logic                   ram_we, ram_re_a, ram_re_b;
    logic [IW-1:0]          ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [INDEX_WIDTH-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;
    logic [INDEX_WIDTH-1:0] val_a, val_b;

    gnps_pkg::t_sym code_arr [MAX_DIMS];
    logic [IW-1:0]  i_prev;
    logic           anti, i_last, k_last, load_ok;
    logic signed [1:0] cur_sign;

    for (genvar p = 0; p < MAX_DIMS; p++) begin : g_code
        if (p < gnps_pkg::CODE_SLOTS) begin : g_live
            assign code_arr[p] = gnps_pkg::t_sym'(r_sym_codes[2*p +: 2]);
        end else begin : g_none
            assign code_arr[p] = gnps_pkg::SYM_NONE;
        end
    end

    gnps_ram #(
        .WIDTH (INDEX_WIDTH),
        .DEPTH (MAX_DIMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re_a    (ram_re_a),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_re_b    (ram_re_b),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (ram_rdata_b)
    );

    // entries never written read as zero
    assign val_a  = r_rvld_a ? ram_rdata_a : '0;
    assign val_b  = r_rvld_b ? ram_rdata_b : '0;
    assign i_prev = r_i - IW'(1);
    assign anti   = (r_i != '0) && (code_arr[i_prev] == gnps_pkg::SYM_ANTI);
    assign i_last = (CW'(r_i) + CW'(1)) == r_n;
    assign k_last = (CW'(r_k) + CW'(1)) == r_n;
    assign load_ok = 32'(i_in.position) < 32'(MAX_DIMS);
    assign cur_sign = r_fin ? gnps_pkg::SIGN_ZERO
                    : (r_neg ? gnps_pkg::SIGN_NEG : gnps_pkg::SIGN_POS);

    assign i_in.ready = i_ctrl.idle;

    always_comb begin
        o_stat.adv_accept = i_in.valid && i_ctrl.idle
                            && (i_in.kind == gnps_pkg::KIND_ADVANCE);
        o_stat.n_zero     = (r_n == '0);
        o_stat.group_end  = (code_arr[r_i] == gnps_pkg::SYM_NONE) || i_last;
        o_stat.i_eq_start = (r_i == r_start);
        o_stat.less       = (val_a < val_b);
        o_stat.l_eq_start = (r_l == r_start);
        o_stat.a_ge_b     = (r_a >= r_b);
        o_stat.wrapping   = r_wrap;
        o_stat.i_last     = i_last;
        o_stat.out_busy   = r_out_valid && !o_out.ready;
        o_stat.k_last     = k_last;
    end

    always_comb begin
        n_vld = r_vld;  n_rvld_a = r_rvld_a;  n_rvld_b = r_rvld_b;
        n_n = r_n;  n_start = r_start;  n_i = r_i;  n_l = r_l;  n_m = r_m;
        n_a = r_a;  n_b = r_b;  n_k = r_k;
        n_neg = r_neg;  n_fin = r_fin;  n_par = r_par;  n_wrap = r_wrap;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_pos = r_out_pos;  n_out_val = r_out_val;
        n_out_sign = r_out_sign;  n_out_last = r_out_last;
        ram_we = 1'b0;  ram_waddr = r_l;  ram_wdata = val_b;
        ram_re_a = 1'b0;  ram_raddr_a = r_l;
        ram_re_b = 1'b0;  ram_raddr_b = r_m;

        unique case (i_ctrl.op)
            gnps_pkg::OP_NOP: begin
            end
            gnps_pkg::OP_IDLE: begin
                if (i_in.valid && i_in.kind == gnps_pkg::KIND_LOAD && load_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = IW'(i_in.position);
                    ram_wdata = INDEX_WIDTH'(i_in.index_value);
                end
                if (o_stat.adv_accept) begin
                    if (32'(r_dim_count) > 32'(MAX_DIMS)) begin
                        n_n = CW'(MAX_DIMS);
                    end else begin
                        n_n = CW'(r_dim_count);
                    end
                    n_start = '0;
                    n_i     = '0;
                    n_neg   = 1'b0;
                    n_fin   = 1'b0;
                end
            end
            gnps_pkg::OP_INC_I: n_i = r_i + IW'(1);
            gnps_pkg::OP_SET_L: n_l = i_prev;
            gnps_pkg::OP_RD_L: begin
                ram_re_a    = 1'b1;
                ram_raddr_a = r_l;
                ram_re_b    = 1'b1;
                ram_raddr_b = r_l + IW'(1);
            end
            gnps_pkg::OP_DEC_L: n_l = r_l - IW'(1);
            gnps_pkg::OP_SET_M: n_m = r_i;
            gnps_pkg::OP_RD_M: begin
                ram_re_a    = 1'b1;
                ram_raddr_a = r_l;
                ram_re_b    = 1'b1;
                ram_raddr_b = r_m;
            end
            gnps_pkg::OP_DEC_M: n_m = r_m - IW'(1);
            gnps_pkg::OP_WR_L: begin
                ram_we    = 1'b1;
                ram_waddr = r_l;
                ram_wdata = val_b;
            end
            gnps_pkg::OP_WR_M: begin
                ram_we    = 1'b1;
                ram_waddr = r_m;
                ram_wdata = val_a;
                n_neg     = r_neg ^ anti;
            end
            gnps_pkg::OP_SET_TAIL: begin
                n_a    = r_l + IW'(1);
                n_b    = r_i;
                n_par  = 1'b0;
                n_wrap = 1'b0;
            end
            gnps_pkg::OP_SET_WRAP: begin
                n_a    = r_start;
                n_b    = r_i;
                n_par  = 1'b0;
                n_wrap = 1'b1;
            end
            gnps_pkg::OP_RD_AB: begin
                ram_re_a    = 1'b1;
                ram_raddr_a = r_a;
                ram_re_b    = 1'b1;
                ram_raddr_b = r_b;
            end
            gnps_pkg::OP_WR_A: begin
                ram_we    = 1'b1;
                ram_waddr = r_a;
                ram_wdata = val_b;
            end
            gnps_pkg::OP_WR_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_b;
                ram_wdata = val_a;
                n_a       = r_a + IW'(1);
                n_b       = r_b - IW'(1);
                n_par     = !r_par;
            end
            gnps_pkg::OP_PARITY: n_neg = r_neg ^ (anti && r_par);
            gnps_pkg::OP_NEXT_GRP: begin
                if (i_last) begin
                    n_fin = 1'b1;
                end else begin
                    n_start = r_i + IW'(1);
                    n_i     = r_i + IW'(1);
                end
            end
            gnps_pkg::OP_SET_K: n_k = '0;
            gnps_pkg::OP_RD_K: begin
                ram_re_a    = 1'b1;
                ram_raddr_a = r_k;
            end
            gnps_pkg::OP_EMIT: begin
                n_out_valid = 1'b1;
                n_out_pos   = POS_W'(r_k);
                n_out_val   = VAL_W'(val_a);
                n_out_sign  = cur_sign;
                n_out_last  = k_last;
                n_k         = r_k + IW'(1);
            end
            gnps_pkg::OP_EMIT_EMPTY: begin
                n_out_valid = 1'b1;
                n_out_pos   = '0;
                n_out_val   = '0;
                n_out_sign  = gnps_pkg::SIGN_ZERO;
                n_out_last  = 1'b1;
            end
            default: begin
            end
        endcase

        if (ram_we) begin
            n_vld[ram_waddr] = 1'b1;
        end
        if (ram_re_a) begin
            n_rvld_a = n_vld[ram_raddr_a] && r_vld[ram_raddr_a];
        end
        if (ram_re_b) begin
            n_rvld_b = r_vld[ram_raddr_b];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= '0;
            r_sym_codes <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (gnps_pkg::t_cfg_reg'(i_cfg_idx))
                    gnps_pkg::CFG_DIM_COUNT:
                        r_dim_count <= i_cfg_wdata[gnps_pkg::DIM_W-1:0];
                    gnps_pkg::CFG_SYM_CODES:
                        r_sym_codes <= i_cfg_wdata[gnps_pkg::CODES_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        r_rvld_a <= n_rvld_a;  r_rvld_b <= n_rvld_b;
        r_n <= n_n;  r_start <= n_start;  r_i <= n_i;  r_l <= n_l;  r_m <= n_m;
        r_a <= n_a;  r_b <= n_b;  r_k <= n_k;
        r_neg <= n_neg;  r_fin <= n_fin;  r_par <= n_par;  r_wrap <= n_wrap;
        r_out_pos <= n_out_pos;  r_out_val <= n_out_val;
        r_out_sign <= n_out_sign;  r_out_last <= n_out_last;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_position = r_out_pos;
    assign o_out.out_value    = r_out_val;
    assign o_out.sign         = r_out_sign;
    assign o_out.last         = r_out_last;
endmodule

### rtl/core/grouped_next_permutation_sign_core.sv
// top level of the grouped next-permutation and sign core
`timescale 1ns / 1ps
`include "assert_macros.svh"
// usage
//   i_in carries items: kind load writes index_value at position (no result);
//   kind advance steps the tuple to its next grouped permutation
//   and then emits one result per position in use, last set on the final one
//   (an empty tuple gives a single zero result with sign 0)
//   o_out carries the results through an output register; when the receiver
//   holds ready low the register keeps its item and the program waits
//   i_cfg_we / i_cfg_idx / i_cfg_wdata write dim_count (0) and the symmetry
//   codes (1); write them only while the core is idle
// timing
//   i_in.ready is high while the sequencer sits in its idle step, so a load
//   is taken in the idle step and the next item may follow straight after
//   an advance runs a microcoded program, one control word per cycle, over a
//   store with two registered read ports and one write port: it scans each
//   group, searches the pivot and its successor, swaps them and reverses the
//   tail (a group at its last permutation is reversed whole and the carry
//   moves on), then emits one result per position in use
// reset
//   synchronous, active low: store reads as zero, both registers cleared,
//   sequencer idle, no result pending
module grouped_next_permutation_sign_core #(
    parameter int MAX_DIMS    = 8,
    parameter int INDEX_WIDTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [gnps_pkg::CFG_W-1:0] i_cfg_wdata,
    gnps_in_if.sink                    i_in,
    gnps_out_if.source                 o_out
);
    // sequencer control word out, datapath flags back
    gnps_pkg::t_ctrl w_ctrl;
    gnps_pkg::t_stat w_stat;

    gnps_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    gnps_dp #(
        .MAX_DIMS    (MAX_DIMS),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_in        (i_in),
        .o_out       (o_out)
    );

    // an accepted advance always enters the program at its first step
    `ASSERT_NEXT(a_adv_enters_program, w_stat.adv_accept, w_ctrl.pc == gnps_pkg::S_CHK)

    // a result only appears out of one of the two emit steps
    `ASSERT_IMPLIES(a_result_from_emit, $rose(o_out.valid), $past(w_ctrl.pc == gnps_pkg::S_EMIT_OUT || w_ctrl.pc == gnps_pkg::S_EMPTY_OUT))

    // the idle step always issues the idle operation
    `ASSERT_IMPLIES(a_idle_no_wait, w_ctrl.idle, w_ctrl.op == gnps_pkg::OP_IDLE)
endmodule

### tb/testbench.sv
// self-checking testbench of the grouped next-permutation and sign core
`timescale 1ns / 1ps
module testbench;

    // settle time after the last result, above the worst advance latency
    localparam int SETTLE_CYCLES  = 150;
    // long receiver hold-off that fills the output register and stalls input
    localparam int HOLD_CYCLES    = 400;
    // cycles with no item moved on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 3000;

    // receiver stall patterns
    typedef enum int {
        RX_FLOW,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    // one emitted value of an advance
    typedef struct {
        logic [gnps_pkg::POS_W-1:0] out_position;
        logic [gnps_pkg::VAL_W-1:0] out_value;
        logic signed [1:0]          sign;
        logic                       last;
    } t_emit;

    // tracks tuple, registers and the emits still owed by the core
    class perm_scoreboard;
        logic [gnps_pkg::VAL_W-1:0] tuple [8];
        logic [gnps_pkg::DIM_W-1:0] dims;
        logic [gnps_pkg::CODES_W-1:0] codes;
        t_emit expected_emits [$];
        int mismatches;

        function new();
            foreach (tuple[p]) tuple[p] = '0;
            dims       = '0;
            codes      = '0;
            mismatches = 0;
        endfunction

        function void write_reg(gnps_pkg::t_cfg_reg idx, logic [gnps_pkg::CFG_W-1:0] data);
            if (idx == gnps_pkg::CFG_DIM_COUNT) dims = data[gnps_pkg::DIM_W-1:0];
            else codes = data[gnps_pkg::CODES_W-1:0];
        endfunction

        function gnps_pkg::t_sym code_at(int p);
            if (p < 0 || p >= gnps_pkg::CODE_SLOTS) return gnps_pkg::SYM_NONE;
            return gnps_pkg::t_sym'(codes[2*p +: 2]);
        endfunction

        // reverses entries a..b, gives back how many swaps it took
        function int reverse_span(int a, int b);
            int swaps;
            logic [gnps_pkg::VAL_W-1:0] t;
            swaps = 0;
            while (a < b) begin
                t        = tuple[a];
                tuple[a] = tuple[b];
                tuple[b] = t;
                a++;
                b--;
                swaps++;
            end
            return swaps;
        endfunction

        function int pending();
            return expected_emits.size();
        endfunction

        // accepted input item: load, or advance and queue the emits
        function void note_item(gnps_pkg::t_kind kind, logic [gnps_pkg::POS_W-1:0] pos,
                                logic [gnps_pkg::VAL_W-1:0] val);
            int n, i, start, l, m, k, sw;
            bit neg, finished, anti;
            logic [gnps_pkg::VAL_W-1:0] t;
            logic signed [1:0] sgn;
            t_emit e;
            if (kind == gnps_pkg::KIND_LOAD) begin
                tuple[pos] = val;
                return;
            end
            n = (dims > 4'd8) ? 8 : int'(dims);
            if (n == 0) begin
                e.out_position = '0;
                e.out_value    = '0;
                e.sign         = gnps_pkg::SIGN_ZERO;
                e.last         = 1'b1;
                expected_emits.push_back(e);
                return;
            end
            neg      = 1'b0;
            finished = 1'b0;
            start    = 0;
            for (i = 0; i < n; i++) begin
                if (code_at(i) != gnps_pkg::SYM_NONE && i != n - 1) continue;
                anti = (i > 0) && (code_at(i - 1) == gnps_pkg::SYM_ANTI);
                for (l = i - 1; l >= start; l--)
                    if (tuple[l] < tuple[l + 1]) break;
                if (l < start) begin
                    // group at its last permutation: back to its first, carry on
                    sw = reverse_span(start, i);
                    if (sw[0] && anti) neg = !neg;
                    if (i == n - 1) finished = 1'b1;
                    start = i + 1;
                    continue;
                end
                for (m = i; m > l; m--)
                    if (tuple[l] < tuple[m]) break;
                t        = tuple[l];
                tuple[l] = tuple[m];
                tuple[m] = t;
                if (anti) neg = !neg;
                sw = reverse_span(l + 1, i);
                if (sw[0] && anti) neg = !neg;
                break;
            end
            sgn = finished ? gnps_pkg::SIGN_ZERO
                           : (neg ? gnps_pkg::SIGN_NEG : gnps_pkg::SIGN_POS);
            for (k = 0; k < n; k++) begin
                e.out_position = k[gnps_pkg::POS_W-1:0];
                e.out_value    = tuple[k];
                e.sign         = sgn;
                e.last         = (k == n - 1);
                expected_emits.push_back(e);
            end
        endfunction

        // accepted result item against the oldest owed emit
        function void check_result(logic [gnps_pkg::POS_W-1:0] pos,
                                   logic [gnps_pkg::VAL_W-1:0] val,
                                   logic signed [1:0] sgn, logic lst);
            t_emit want;
            if (expected_emits.size() == 0) begin
                $error("unexpected result: out_position %0d out_value %0d sign %0d last %0d",
                       pos, val, sgn, lst);
                mismatches++;
                return;
            end
            want = expected_emits.pop_front();
            if (pos !== want.out_position) begin
                $error("out_position: expected %0d, actual %0d", want.out_position, pos);
                mismatches++;
            end
            if (val !== want.out_value) begin
                $error("out_value: expected %0d, actual %0d", want.out_value, val);
                mismatches++;
            end
            if (sgn !== want.sign) begin
                $error("sign: expected %0d, actual %0d", want.sign, sgn);
                mismatches++;
            end
            if (lst !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, lst);
                mismatches++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    gnps_pkg::t_cfg_reg         i_cfg_idx;
    logic [gnps_pkg::CFG_W-1:0] i_cfg_wdata;

    gnps_in_if  in_if ();
    gnps_out_if out_if ();

    perm_scoreboard sb;
    int burst_left   = 0;
    bit hold_pending = 1'b0;
    int quiet_cycles;

    grouped_next_permutation_sign_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #5 i_clk = ~i_clk;

    // mostly small values so duplicates and long permutation runs show up
    function automatic logic [gnps_pkg::VAL_W-1:0] rand_value();
        if ($urandom_range(0, 4) == 0) return gnps_pkg::VAL_W'($urandom_range(0, 255));
        return gnps_pkg::VAL_W'($urandom_range(0, 3));
    endfunction

    // dim_count word: empty, saturating or in range, junk in the unused bits
    function automatic logic [gnps_pkg::CFG_W-1:0] rand_dim_word();
        int r;
        logic [gnps_pkg::DIM_W-1:0] d;
        r = $urandom_range(0, 9);
        if (r == 0) d = '0;
        else if (r == 1) d = gnps_pkg::DIM_W'($urandom_range(9, 15));
        else d = gnps_pkg::DIM_W'($urandom_range(1, 8));
        return {(gnps_pkg::CFG_W - gnps_pkg::DIM_W)'($urandom), d};
    endfunction

    // symmetry codes with plenty of group ends so the carry is exercised
    function automatic logic [gnps_pkg::CODES_W-1:0] rand_codes();
        logic [gnps_pkg::CODES_W-1:0] c;
        int r;
        for (int p = 0; p < gnps_pkg::CODE_SLOTS; p++) begin
            r = $urandom_range(0, 9);
            if (r < 3) c[2*p +: 2] = gnps_pkg::SYM_NONE;
            else if (r < 6) c[2*p +: 2] = gnps_pkg::SYM_SYM;
            else if (r < 9) c[2*p +: 2] = gnps_pkg::SYM_ANTI;
            else c[2*p +: 2] = gnps_pkg::SYM_HERM;
        end
        return c;
    endfunction

    // offers one item, bursts with random gaps between them
    task automatic send_item(gnps_pkg::t_kind kind, logic [gnps_pkg::POS_W-1:0] pos,
                             logic [gnps_pkg::VAL_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_if.valid       <= 1'b1;
        in_if.kind        <= kind;
        in_if.position    <= pos;
        in_if.index_value <= val;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(kind, pos, val);
        burst_left--;
    endtask

    task automatic send_advance();
        send_item(gnps_pkg::KIND_ADVANCE, gnps_pkg::POS_W'($urandom),
                  gnps_pkg::VAL_W'($urandom));
    endtask

    // sender stops until every owed result is in, then the core settles
    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(gnps_pkg::t_cfg_reg idx, logic [gnps_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // registers only change with the core idle
    task automatic set_config(logic [gnps_pkg::CFG_W-1:0] dim_word,
                              logic [gnps_pkg::CODES_W-1:0] code_word);
        drain();
        cfg_write(gnps_pkg::CFG_DIM_COUNT, dim_word);
        cfg_write(gnps_pkg::CFG_SYM_CODES, gnps_pkg::CFG_W'(code_word));
    endtask

    // fill the tuple, then mostly advances with the odd load in between
    task automatic random_phase(int n_items);
        for (int p = 0; p < 8; p++)
            send_item(gnps_pkg::KIND_LOAD, gnps_pkg::POS_W'(p), rand_value());
        for (int k = 8; k < n_items; k++) begin
            if ($urandom_range(0, 4) == 0)
                send_item(gnps_pkg::KIND_LOAD, gnps_pkg::POS_W'($urandom_range(0, 7)),
                          rand_value());
            else
                send_advance();
        end
    endtask

    // result side: check every accepted item
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid && out_if.ready)
            sb.check_result(out_if.out_position, out_if.out_value, out_if.sign, out_if.last);
    end

    // receiver ready pattern, with a long hold-off on request
    initial begin
        int run_left;
        t_rx_mode mode;
        out_if.ready = 1'b0;
        run_left     = 0;
        mode         = RX_FLOW;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (run_left == 0) begin
                mode     = t_rx_mode'($urandom_range(0, 2));
                run_left = $urandom_range(4, 48);
            end
            run_left--;
            case (mode)
                RX_FLOW:  out_if.ready <= 1'b1;
                RX_COIN:  out_if.ready <= 1'($urandom_range(0, 1));
                default:  out_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog: too long with nothing moving on either channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = gnps_pkg::CFG_DIM_COUNT;
        i_cfg_wdata       = '0;
        in_if.valid       = 1'b0;
        in_if.kind        = gnps_pkg::KIND_LOAD;
        in_if.position    = '0;
        in_if.index_value = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty tuple straight out of reset
        send_advance();

        // one antisymmetric group of three, walked past its wrap
        set_config(16'h0003, 16'h000A);
        send_item(gnps_pkg::KIND_LOAD, 3'd0, 8'd1);
        send_item(gnps_pkg::KIND_LOAD, 3'd1, 8'd2);
        send_item(gnps_pkg::KIND_LOAD, 3'd2, 8'd3);
        repeat (7) send_advance();

        // dim_count saturating, all hermitian, extreme values and positions
        set_config(16'hFFFF, 16'hFFFF);
        send_item(gnps_pkg::KIND_LOAD, 3'd7, 8'd255);
        send_item(gnps_pkg::KIND_LOAD, 3'd0, 8'd0);
        repeat (2) send_advance();

        // every position its own group: immediate wrap, sign zero
        set_config(16'h5A04, 16'h0000);
        send_advance();

        // single position
        set_config(16'h0001, 16'hAAAA);
        send_advance();

        // two antisymmetric groups, duplicate values, carry into the second
        set_config(16'h0004, 16'h00A2);
        send_item(gnps_pkg::KIND_LOAD, 3'd0, 8'd5);
        send_item(gnps_pkg::KIND_LOAD, 3'd1, 8'd5);
        send_item(gnps_pkg::KIND_LOAD, 3'd2, 8'd1);
        send_item(gnps_pkg::KIND_LOAD, 3'd3, 8'd7);
        repeat (3) send_advance();

        // full tuple while the receiver holds off: output fills, input stalls
        set_config(16'h0008, rand_codes());
        for (int p = 0; p < 8; p++)
            send_item(gnps_pkg::KIND_LOAD, gnps_pkg::POS_W'(p),
                      gnps_pkg::VAL_W'($urandom_range(0, 3)));
        hold_pending = 1'b1;
        burst_left   = 64;
        repeat (12) send_advance();

        // random settings, each phase from an idle core
        for (int ph = 0; ph < 5; ph++) begin
            set_config(rand_dim_word(), rand_codes());
            random_phase(21);
        end

        drain();
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/gnps_pkg.sv
rtl/core/gnps_in_if.sv
rtl/core/gnps_out_if.sv
rtl/core/gnps_ram.sv
rtl/core/gnps_seq.sv
rtl/core/gnps_dp.sv
rtl/core/grouped_next_permutation_sign_core.sv
tb/testbench.sv
